// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define TRP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("trp assertion failed");

// checked on every edge, reset included
`define TRP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("trp assertion failed");

`endif

// ===== rtl/trp_pkg.sv =====
// types and constants of the trie root prefix replacer
package trp_pkg;

    typedef enum logic [1:0] {
        CMD_DICT_LETTER,
        CMD_DICT_END,
        CMD_SENT_BYTE,
        CMD_CLEAR
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK,
        ST_FULL,
        ST_BADCH
    } t_status;

    typedef enum logic {
        KIND_BYTE,
        KIND_STATUS
    } t_kind;

    localparam logic [7:0] CH_BASE  = 8'd97;
    localparam logic [7:0] CH_SPACE = 8'd32;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] out_char;
        t_status    status;
    } t_res;

    typedef struct packed {
        logic vld;
        t_res res;
    } t_push;

endpackage

// ===== rtl/trp_node_mem.sv =====
// child pointer memory with end flags and a reset overlay for the root row
module trp_node_mem
    import trp_pkg::*;
#(
    parameter int NW = 10,
    parameter int AW = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clr,
    input  logic             i_we,
    input  logic [NW+AW-1:0] i_waddr,
    input  logic [NW:0]      i_wdata,
    input  logic             i_re,
    input  logic [NW+AW-1:0] i_raddr,
    output logic [NW:0]      o_rdata
);

    localparam int ADDR  = NW + AW;
    localparam int DEPTH = 1 << ADDR;
    localparam int ROWW  = 1 << AW;

    logic [NW:0]     r_mem [DEPTH];
    logic [NW:0]     r_rdata;
    logic            r_rd_ok;
    logic [ROWW-1:0] r_root_vld;

    logic w_wr_root;
    logic w_rd_root;

    assign w_wr_root = (i_waddr[ADDR-1:AW] == '0);
    assign w_rd_root = (i_raddr[ADDR-1:AW] == '0);

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
            r_rd_ok <= !w_rd_root || r_root_vld[i_raddr[AW-1:0]];
        end
    end

    // root row reads as null until written since reset or clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_root_vld <= '0;
        end else if (i_we && w_wr_root) begin
            r_root_vld[i_waddr[AW-1:0]] <= 1'b1;
        end
    end

    assign o_rdata = r_rd_ok ? r_rdata : '0;

endmodule

// ===== rtl/trp_ctrl.sv =====
// sequencer for dictionary insertion, row nulling and sentence scanning
module trp_ctrl
    import trp_pkg::*;
#(
    parameter int POOL_NODES = 1024,
    parameter int ALPHABET   = 26,
    parameter int NW         = 10,
    parameter int AW         = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_vld,
    output logic             o_s_rdy,
    input  logic [1:0]       i_cmd,
    input  logic [7:0]       i_ch,
    input  logic             i_res_rdy,
    output t_push            o_push,
    output logic             o_clr,
    output logic             o_we,
    output logic [NW+AW-1:0] o_waddr,
    output logic [NW:0]      o_wdata,
    output logic             o_re,
    output logic [NW+AW-1:0] o_raddr,
    input  logic [NW:0]      i_rdata
);

    localparam int ADDR = NW + AW;
    localparam int CW   = $clog2(POOL_NODES + 1);
    localparam logic [8:0]    LETTER_END = 9'(int'(CH_BASE) + ALPHABET);
    localparam logic [CW-1:0] POOL_FULL  = CW'(POOL_NODES);
    localparam logic [AW-1:0] IDX_LAST   = AW'(ALPHABET - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRD,
        S_DRD,
        S_NULL,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        M_WALK,
        M_CUT,
        M_PASS
    } t_mode;

    t_state        r_state,    n_state;
    logic [CW-1:0] r_used,     n_used;
    logic [NW-1:0] r_dict_cur, n_dict_cur;
    t_status       r_dict_err, n_dict_err;
    logic [ADDR-1:0] r_link,   n_link;
    logic [NW-1:0] r_scan_cur, n_scan_cur;
    t_mode         r_mode,     n_mode;
    logic [7:0]    r_ch,       n_ch;
    logic [ADDR-1:0] r_addr,   n_addr;
    logic [NW-1:0] r_null_node, n_null_node;
    logic [AW-1:0] r_null_cnt, n_null_cnt;
    t_res          r_res,      n_res;

    logic          w_letter;
    logic [7:0]    w_diff;
    logic [AW-1:0] w_idx;
    logic [NW-1:0] w_nxt;
    logic [NW-1:0] w_new;
    logic          w_emit;
    t_res          w_res;
    t_cmd          w_cmd;

    assign w_cmd    = t_cmd'(i_cmd);
    assign w_letter = ({1'b0, i_ch} >= {1'b0, CH_BASE}) && ({1'b0, i_ch} < LETTER_END);
    assign w_diff   = i_ch - CH_BASE;
    assign w_idx    = w_diff[AW-1:0];
    assign w_nxt    = i_rdata[NW-1:0];
    assign w_new    = r_used[NW-1:0];
    assign o_s_rdy  = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_dict_cur  = r_dict_cur;
        n_dict_err  = r_dict_err;
        n_link      = r_link;
        n_scan_cur  = r_scan_cur;
        n_mode      = r_mode;
        n_ch        = r_ch;
        n_addr      = r_addr;
        n_null_node = r_null_node;
        n_null_cnt  = r_null_cnt;
        n_res       = r_res;
        w_emit      = 1'b0;
        w_res       = '{kind: KIND_BYTE, out_char: r_ch, status: ST_OK};
        o_push      = '0;
        o_clr       = 1'b0;
        o_we        = 1'b0;
        o_waddr     = r_addr;
        o_wdata     = '0;
        o_re        = 1'b0;
        o_raddr     = {r_dict_cur, w_idx};

        case (r_state)
            S_IDLE: begin
                if (i_s_vld) begin
                    n_ch = i_ch;
                    case (w_cmd)
                        CMD_DICT_LETTER: begin
                            if (r_dict_err == ST_OK) begin
                                if (!w_letter) begin
                                    n_dict_err = ST_BADCH;
                                end else begin
                                    o_re    = 1'b1;
                                    o_raddr = {r_dict_cur, w_idx};
                                    n_addr  = o_raddr;
                                    n_state = S_DRD;
                                end
                            end
                        end
                        CMD_DICT_END: begin
                            w_emit = 1'b1;
                            w_res  = '{kind: KIND_STATUS, out_char: 8'd0, status: r_dict_err};
                            if (r_dict_err == ST_OK && r_dict_cur != '0) begin
                                o_we    = 1'b1;
                                o_waddr = r_link;
                                o_wdata = {1'b1, r_dict_cur};
                            end
                            n_dict_cur = '0;
                            n_dict_err = ST_OK;
                        end
                        CMD_SENT_BYTE: begin
                            w_res = '{kind: KIND_BYTE, out_char: i_ch, status: ST_OK};
                            if (i_ch == CH_SPACE) begin
                                n_scan_cur = '0;
                                n_mode     = M_WALK;
                                w_emit     = 1'b1;
                            end else if (r_mode == M_CUT) begin
                                w_emit = 1'b0;
                            end else if (r_mode == M_WALK && w_letter) begin
                                o_re    = 1'b1;
                                o_raddr = {r_scan_cur, w_idx};
                                n_state = S_SRD;
                            end else begin
                                n_mode = M_PASS;
                                w_emit = 1'b1;
                            end
                        end
                        CMD_CLEAR: begin
                            o_clr      = 1'b1;
                            n_used     = CW'(1);
                            n_dict_cur = '0;
                            n_dict_err = ST_OK;
                            n_scan_cur = '0;
                            n_mode     = M_WALK;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SRD: begin
                w_emit  = 1'b1;
                n_state = S_IDLE;
                if (w_nxt == '0) begin
                    n_mode = M_PASS;
                end else begin
                    n_scan_cur = w_nxt;
                    n_mode     = i_rdata[NW] ? M_CUT : M_WALK;
                end
            end
            S_DRD: begin
                n_state = S_IDLE;
                if (w_nxt != '0) begin
                    n_dict_cur = w_nxt;
                    n_link     = r_addr;
                end else if (r_used == POOL_FULL) begin
                    n_dict_err = ST_FULL;
                end else begin
                    o_we        = 1'b1;
                    o_waddr     = r_addr;
                    o_wdata     = {1'b0, w_new};
                    n_used      = r_used + CW'(1);
                    n_dict_cur  = w_new;
                    n_link      = r_addr;
                    n_null_node = w_new;
                    n_null_cnt  = '0;
                    n_state     = S_NULL;
                end
            end
            S_NULL: begin
                o_we    = 1'b1;
                o_waddr = {r_null_node, r_null_cnt};
                o_wdata = '0;
                if (r_null_cnt == IDX_LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_null_cnt = r_null_cnt + AW'(1);
                end
            end
            S_EMIT: begin
                if (i_res_rdy) begin
                    o_push  = '{vld: 1'b1, res: r_res};
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_emit) begin
            if (i_res_rdy) begin
                o_push = '{vld: 1'b1, res: w_res};
            end else begin
                n_res   = w_res;
                n_state = S_EMIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_used     <= CW'(1);
            r_dict_cur <= '0;
            r_dict_err <= ST_OK;
            r_scan_cur <= '0;
            r_mode     <= M_WALK;
        end else begin
            r_state    <= n_state;
            r_used     <= n_used;
            r_dict_cur <= n_dict_cur;
            r_dict_err <= n_dict_err;
            r_scan_cur <= n_scan_cur;
            r_mode     <= n_mode;
        end
        r_link      <= n_link;
        r_ch        <= n_ch;
        r_addr      <= n_addr;
        r_null_node <= n_null_node;
        r_null_cnt  <= n_null_cnt;
        r_res       <= n_res;
    end

endmodule

// ===== rtl/trie_root_prefix_replacer.sv =====
// top level of the trie root prefix replacer: memory, sequencer, output register
// A space, a byte after the root of its word, a byte of an unmatched word, a word end
// and a clear are handled in the idle state; a sentence letter still walking the trie
// also passes S_SRD after the registered read of the child memory; a dictionary letter
// passes S_DRD, and when a node is allocated also S_NULL, where the new row is
// nulled one entry a cycle through the single write port. No clearing pass follows reset.
`include "assert_macros.svh"

module trie_root_prefix_replacer
    import trp_pkg::*;
#(
    parameter int POOL_NODES = 1024,
    parameter int ALPHABET   = 26
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // ch
    input  logic [1:0]  i_s_axis_tuser,   // cmd
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // out_char, insert_status
    output logic [0:0]  o_m_axis_tuser    // kind
);

    localparam int NW   = $clog2(POOL_NODES);
    localparam int AW   = $clog2(ALPHABET);
    localparam int ADDR = NW + AW;

    t_push           w_push;
    logic            w_res_rdy;
    logic            w_clr;
    logic            w_we;
    logic [ADDR-1:0] w_waddr;
    logic [NW:0]     w_wdata;
    logic            w_re;
    logic [ADDR-1:0] w_raddr;
    logic [NW:0]     w_rdata;

    logic r_out_vld;
    t_res r_out;

    assign w_res_rdy = !r_out_vld || i_m_axis_tready;

    trp_ctrl #(
        .POOL_NODES (POOL_NODES),
        .ALPHABET   (ALPHABET),
        .NW         (NW),
        .AW         (AW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_vld   (i_s_axis_tvalid),
        .o_s_rdy   (o_s_axis_tready),
        .i_cmd     (i_s_axis_tuser),
        .i_ch      (i_s_axis_tdata),
        .i_res_rdy (w_res_rdy),
        .o_push    (w_push),
        .o_clr     (w_clr),
        .o_we      (w_we),
        .o_waddr   (w_waddr),
        .o_wdata   (w_wdata),
        .o_re      (w_re),
        .o_raddr   (w_raddr),
        .i_rdata   (w_rdata)
    );

    trp_node_mem #(
        .NW (NW),
        .AW (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (w_clr),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_push.vld) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
        if (w_push.vld) begin
            r_out <= w_push.res;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {6'd0, r_out.status, r_out.out_char};
    assign o_m_axis_tuser  = r_out.kind;

    `TRP_ASSERT(a_push_has_room, i_clk, i_rst_n, w_push.vld |-> w_res_rdy)
    `TRP_ASSERT(a_no_rd_wr_overlap, i_clk, i_rst_n, !(w_we && w_re))
    `TRP_ASSERT_ALWAYS(a_reset_empties_out, i_clk, !i_rst_n |=> !o_m_axis_tvalid)

endmodule

// ===== test/tb_trie_root_prefix_replacer.sv =====
// testbench of the trie root prefix replacer: directed table and random traffic
`timescale 1ns / 1ps

module tb_trie_root_prefix_replacer;
    import trp_pkg::*;

    localparam int POOL        = 1024;
    localparam int ALPH        = 26;
    localparam int HOLD_CYCLES = 400;

    typedef enum logic [1:0] {
        SCAN_WALK,
        SCAN_CUT,
        SCAN_PASS
    } t_scan;

    typedef struct {
        t_cmd       cmd;
        logic [7:0] ch;
        bit         typed;
        t_res       res;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = 8'h00;   // ch
    logic [1:0]  i_s_axis_tuser = 2'b00;   // cmd
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;           // out_char, insert_status
    logic [0:0]  o_m_axis_tuser;           // kind

    // trie predictor state
    logic [9:0]  trie_child [0:POOL*ALPH-1];
    bit          trie_end [0:POOL-1];
    int          node_cnt;
    int          peak_nodes;
    logic [9:0]  dict_node;
    t_status     dict_err;
    logic [9:0]  scan_node;
    t_scan       scan_mode;

    t_res        exp_words[$];
    t_dir_row    stim_table[$];
    logic [63:0] root_txt[$];
    int          root_len[$];

    int          src_idle_pct = 0;
    int          sink_idle_pct = 0;
    bit          hold_req = 1'b0;
    int          n_items = 0;
    int          n_results = 0;
    int          n_status = 0;
    int          n_clears = 0;
    int          n_err = 0;
    t_res        want;

    trie_root_prefix_replacer DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic trie_clear();
        foreach (trie_child[i]) trie_child[i] = '0;
        foreach (trie_end[i]) trie_end[i] = 1'b0;
        node_cnt  = 1;
        dict_node = '0;
        dict_err  = ST_OK;
        scan_node = '0;
        scan_mode = SCAN_WALK;
    endtask

    task automatic trie_predict(input t_cmd cmd, input logic [7:0] ch,
                                output bit has_res, output t_res res);
        int         idx;
        bit         is_ltr;
        logic [9:0] nxt;
        has_res = 1'b0;
        res     = '0;
        is_ltr  = (ch >= CH_BASE) && (int'(ch) < int'(CH_BASE) + ALPH);
        idx     = int'(ch) - int'(CH_BASE);
        nxt     = '0;
        case (cmd)
            CMD_DICT_LETTER: begin
                if (dict_err == ST_OK) begin
                    if (!is_ltr) begin
                        dict_err = ST_BADCH;
                    end else begin
                        nxt = trie_child[int'(dict_node) * ALPH + idx];
                        if (nxt == '0) begin
                            if (node_cnt >= POOL) begin
                                dict_err = ST_FULL;
                            end else begin
                                nxt = 10'(node_cnt);
                                node_cnt++;
                                if (node_cnt > peak_nodes) peak_nodes = node_cnt;
                                trie_child[int'(dict_node) * ALPH + idx] = nxt;
                            end
                        end
                        if (dict_err == ST_OK) dict_node = nxt;
                    end
                end
            end
            CMD_DICT_END: begin
                has_res    = 1'b1;
                res.kind   = KIND_STATUS;
                res.status = dict_err;
                n_status++;
                if (dict_err == ST_OK && dict_node != '0) trie_end[dict_node] = 1'b1;
                dict_node = '0;
                dict_err  = ST_OK;
            end
            CMD_SENT_BYTE: begin
                if (ch == CH_SPACE) begin
                    scan_node = '0;
                    scan_mode = SCAN_WALK;
                    has_res   = 1'b1;
                end else if (scan_mode != SCAN_CUT) begin
                    if (scan_mode == SCAN_WALK) begin
                        if (is_ltr) nxt = trie_child[int'(scan_node) * ALPH + idx];
                        if (nxt == '0) begin
                            scan_mode = SCAN_PASS;
                        end else begin
                            scan_node = nxt;
                            if (trie_end[nxt]) scan_mode = SCAN_CUT;
                        end
                    end
                    has_res = 1'b1;
                end
                res.kind     = KIND_BYTE;
                res.out_char = ch;
            end
            default: begin
                n_clears++;
                trie_clear();
            end
        endcase
    endtask

    task automatic issue(input t_cmd cmd, input logic [7:0] ch,
                         input bit typed = 1'b0, input t_res typed_res = '0);
        bit   has_res;
        t_res res;
        trie_predict(cmd, ch, has_res, res);
        if (typed) exp_words = {exp_words, typed_res};
        else if (has_res) exp_words = {exp_words, res};
        n_items++;
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= cmd;
        i_s_axis_tdata  <= ch;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic add_row(input t_cmd cmd, input logic [7:0] ch, input bit typed,
                           input t_kind kind, input logic [7:0] oc, input t_status st);
        t_dir_row row;
        row.cmd          = cmd;
        row.ch           = ch;
        row.typed        = typed;
        row.res.kind     = kind;
        row.res.out_char = oc;
        row.res.status   = st;
        stim_table       = {stim_table, row};
    endtask

    // any byte that is neither a lowercase letter nor a space
    function automatic logic [7:0] odd_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255));
        while ((b >= CH_BASE && b < CH_BASE + 8'(ALPH)) || b == CH_SPACE);
        return b;
    endfunction

    task automatic random_burst();
        int          r, len, k, i, nw, pick, badpos;
        bit          bad, narrow;
        logic [63:0] txt;
        logic [7:0]  b;
        r = $urandom_range(99);
        if (r < 30) begin
            // root word, sometimes with a bad byte in it
            len    = ($urandom_range(9) == 0) ? $urandom_range(6, 8) : $urandom_range(1, 4);
            bad    = ($urandom_range(9) == 0);
            badpos = $urandom_range(len - 1);
            narrow = 1'($urandom_range(1));
            txt    = '0;
            for (k = 0; k < len; k++) begin
                b = narrow ? 8'(CH_BASE + $urandom_range(3)) : 8'(CH_BASE + $urandom_range(25));
                if (bad && k == badpos) b = odd_byte();
                txt[8*k +: 8] = b;
                issue(CMD_DICT_LETTER, b);
            end
            issue(CMD_DICT_END, 8'($urandom_range(255)));
            if (!bad && root_txt.size() < 48) begin
                root_txt = {root_txt, txt};
                root_len = {root_len, len};
            end
        end else if (r < 85) begin
            // sentence of roots with tails, unknown words and odd bytes
            nw = $urandom_range(1, 5);
            if ($urandom_range(4) == 0) issue(CMD_SENT_BYTE, CH_SPACE);
            for (i = 0; i < nw; i++) begin
                pick = $urandom_range(99);
                if (pick < 60 && root_txt.size() != 0) begin
                    k   = $urandom_range(root_txt.size() - 1);
                    txt = root_txt[k];
                    for (int m = 0; m < root_len[k]; m++) issue(CMD_SENT_BYTE, txt[8*m +: 8]);
                    len = $urandom_range(3);
                    for (int m = 0; m < len; m++)
                        issue(CMD_SENT_BYTE, 8'(CH_BASE + $urandom_range(m[0] ? 25 : 3)));
                end else begin
                    len    = $urandom_range(1, 6);
                    badpos = (pick >= 85) ? $urandom_range(len - 1) : len;
                    for (int m = 0; m < len; m++)
                        issue(CMD_SENT_BYTE,
                              (m == badpos) ? odd_byte() : 8'(CH_BASE + $urandom_range(3)));
                end
                issue(CMD_SENT_BYTE, CH_SPACE);
                if ($urandom_range(6) == 0) issue(CMD_SENT_BYTE, CH_SPACE);
            end
        end else if (r < 96) begin
            issue(t_cmd'($urandom_range(2)), 8'($urandom_range(255)));
        end else begin
            issue(CMD_CLEAR, 8'($urandom_range(255)));
            root_txt.delete();
            root_len.delete();
        end
    endtask

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            n_results++;
            if (exp_words.size() == 0) begin
                n_err++;
                if (n_err <= 10)
                    $display("unexpected word: kind %0d data %h",
                             o_m_axis_tuser, o_m_axis_tdata);
            end else begin
                want = exp_words.pop_front();
                if (o_m_axis_tuser[0] !== want.kind || o_m_axis_tdata[7:0] !== want.out_char
                    || o_m_axis_tdata[9:8] !== want.status || o_m_axis_tdata[15:10] !== 6'd0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display({"mismatch: expected kind %0d char %h status %0d, ",
                                  "got kind %0d char %h status %0d pad %h"},
                                 want.kind, want.out_char, want.status, o_m_axis_tuser[0],
                                 o_m_axis_tdata[7:0], o_m_axis_tdata[9:8],
                                 o_m_axis_tdata[15:10]);
                end
            end
        end
    end

    initial begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        int target;
        trie_clear();
        peak_nodes = node_cnt;

        add_row(CMD_SENT_BYTE,   "a",   1, KIND_BYTE,   "a",   ST_OK);
        add_row(CMD_SENT_BYTE,   8'hff, 1, KIND_BYTE,   8'hff, ST_OK);
        add_row(CMD_SENT_BYTE,   " ",   1, KIND_BYTE,   " ",   ST_OK);
        add_row(CMD_DICT_END,    8'h00, 1, KIND_STATUS, 8'h00, ST_OK);
        add_row(CMD_DICT_LETTER, "c",   0, KIND_BYTE,   8'h00, ST_OK);
        add_row(CMD_DICT_LETTER, "a",   0, KIND_BYTE,   8'h00, ST_OK);
        add_row(CMD_DICT_END,    8'h00, 1, KIND_STATUS, 8'h00, ST_OK);
        add_row(CMD_DICT_LETTER, "c",   0, KIND_BYTE,   8'h00, ST_OK);
        add_row(CMD_DICT_LETTER, "a",   0, KIND_BYTE,   8'h00, ST_OK);
        add_row(CMD_DICT_LETTER, "t",   0, KIND_BYTE,   8'h00, ST_OK);
        add_row(CMD_DICT_END,    8'h00, 1, KIND_STATUS, 8'h00, ST_OK);
        add_row(CMD_DICT_LETTER, "z",   0, KIND_BYTE,   8'h00, ST_OK);
        add_row(CMD_DICT_END,    8'hff, 1, KIND_STATUS, 8'h00, ST_OK);
        add_row(CMD_DICT_LETTER, 8'h60, 0, KIND_BYTE,   8'h00, ST_OK);
        add_row(CMD_DICT_LETTER, "b",   0, KIND_BYTE,   8'h00, ST_OK);
        add_row(CMD_DICT_END,    8'h00, 1, KIND_STATUS, 8'h00, ST_BADCH);
        add_row(CMD_DICT_LETTER, 8'h7b, 0, KIND_BYTE,   8'h00, ST_OK);
        add_row(CMD_DICT_END,    8'h00, 1, KIND_STATUS, 8'h00, ST_BADCH);
        add_row(CMD_SENT_BYTE,   "c",   0, KIND_BYTE,   8'h00, ST_OK);
        add_row(CMD_SENT_BYTE,   "a",   0, KIND_BYTE,   8'h00, ST_OK);
        add_row(CMD_SENT_BYTE,   "t",   0, KIND_BYTE,   8'h00, ST_OK);
        add_row(CMD_SENT_BYTE,   " ",   1, KIND_BYTE,   " ",   ST_OK);
        add_row(CMD_SENT_BYTE,   "z",   0, KIND_BYTE,   8'h00, ST_OK);
        add_row(CMD_CLEAR,       8'hff, 0, KIND_BYTE,   8'h00, ST_OK);
        add_row(CMD_SENT_BYTE,   "c",   1, KIND_BYTE,   "c",   ST_OK);
        add_row(CMD_SENT_BYTE,   8'h00, 1, KIND_BYTE,   8'h00, ST_OK);
        add_row(CMD_DICT_END,    8'hff, 1, KIND_STATUS, 8'h00, ST_OK);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct  = 32;
        sink_idle_pct = 67;
        foreach (stim_table[n])
            issue(stim_table[n].cmd, stim_table[n].ch, stim_table[n].typed, stim_table[n].res);
        while (n_items < 200) random_burst();

        src_idle_pct  = 67;
        sink_idle_pct = 32;
        while (n_items < 300) random_burst();

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        issue(CMD_CLEAR, 8'h00);
        root_txt.delete();
        root_len.delete();

        // long receiver hold-off while sentence bytes keep coming
        hold_req = 1'b1;
        for (int m = 0; m < 80; m++)
            issue(CMD_SENT_BYTE, (m % 7 == 6) ? CH_SPACE : 8'(CH_BASE + $urandom_range(25)));
        target = n_items + 170;
        while (n_items < target) random_burst();

        i_s_axis_tvalid <= 1'b0;
        while (exp_words.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);

        $display("sent %0d input words under three idle mixes and one long stall, checked %0d",
                 n_items, n_results);
        $display("%0d insertion status words, %0d clears, trie peak %0d nodes, %0d mismatches",
                 n_status, n_clears, peak_nodes, n_err);
        if (n_err == 0 && exp_words.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
